[rtl/neh_pkg.sv]
// Package for the NEH flow-shop scheduler: sizes, sequencer states and the
// control struct of the span unit. No dependencies.
package neh_pkg;

   localparam int MAX_JOBS     = 64;
   localparam int MAX_MACHINES = 16;
   localparam int TIME_BITS    = 16;
   localparam int JOB_BITS     = 6;
   localparam int MACH_BITS    = 4;
   localparam int COUNT_BITS   = 7;
   localparam int MCOUNT_BITS  = 5;
   localparam int TOTAL_BITS   = 20;
   localparam int SPAN_BITS    = 23;
   localparam int TT_ADDR_BITS = JOB_BITS + MACH_BITS;

   localparam logic REG_JOB_COUNT     = 1'b0;
   localparam logic REG_MACHINE_COUNT = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TOT_ADDR,
      ST_TOT_ACC,
      ST_SEL_ADDR,
      ST_SEL_CMP,
      ST_INS_INIT,
      ST_TRIAL_START,
      ST_ELEM_ADDR,
      ST_ELEM_WAIT,
      ST_MAC_ADDR,
      ST_MAC_STEP,
      ST_TRIAL_END,
      ST_SHIFT,
      ST_SHIFT_WR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                 clear;
      logic                 step;
      logic                 first;
      logic [MACH_BITS-1:0] machine;
   } span_ctrl_type;

endpackage

[rtl/neh_span.sv]
// Shared completion-time unit: one max-and-add per cycle in which ctrl.step
// is set, over the machine finish times. Depends on neh_pkg.
module neh_span import neh_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  span_ctrl_type        ctrl,
   input  logic [TIME_BITS-1:0] proc_time,
   output logic [SPAN_BITS-1:0] span
);

   logic [SPAN_BITS-1:0] finish_ff [MAX_MACHINES];
   logic [SPAN_BITS-1:0] prev_ff;
   logic [SPAN_BITS-1:0] ready;
   logic [SPAN_BITS-1:0] sum_in;

   always_comb begin
      ready = finish_ff[ctrl.machine];
      if (!ctrl.first && (prev_ff > ready)) begin
         ready = prev_ff;
      end
      sum_in = ready + SPAN_BITS'(proc_time);
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         for (int m = 0; m < MAX_MACHINES; m++) begin
            finish_ff[m] <= '0;
         end
         prev_ff <= '0;
      end else if (ctrl.step) begin
         finish_ff[ctrl.machine] <= sum_in;
         prev_ff                 <= sum_in;
      end
   end

   assign span = prev_ff;

endmodule

[rtl/neh_flow_shop_scheduler_unit.sv]
// NEH permutation flow-shop scheduler, top level: request and result
// channels, register port, table memories and the sequencer.
// Depends on neh_pkg and neh_span.
//
// Usage: write job_count (byte address 0) and machine_count (address 4)
// through the csr_ port while the block is idle. Then send one request per
// (job, machine) processing time; each is accepted while the block is idle. The
// request with last_entry set also writes its entry and starts scheduling;
// req_stall stays high until the makespan is loaded into the output register.
// Scheduling runs in order: row sums of every job over the machines, a job
// selection per inserted job, and a trial insertion at every sequence
// position; the single max-and-add unit steps one machine at a time, a
// registered table read followed by the update.
// One result carrying the makespan follows each last_entry request; it is
// held in an output register until taken, and the block accepts new table
// requests while it waits. A zero job or machine count gives makespan 0.
// Reset (synchronous) sets both counts to 1 and empties the channels; the
// table contents stay undefined until written.
module neh_flow_shop_scheduler_unit import neh_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [JOB_BITS-1:0]    req_job_index,
   input  logic [MACH_BITS-1:0]   req_machine_index,
   input  logic [TIME_BITS-1:0]   req_proc_time,
   input  logic                   req_last_entry,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [SPAN_BITS-1:0]   rsp_makespan,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [2:0]             csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);

   state_type state_ff, state_in;

   logic [COUNT_BITS-1:0]  job_count_ff;
   logic [MCOUNT_BITS-1:0] machine_count_ff;
   logic [COUNT_BITS-1:0]  nj;
   logic [MCOUNT_BITS-1:0] nm;

   logic [COUNT_BITS-1:0]  cnt_ff, pos_ff, placed_ff, best_slot_ff;
   logic [MACH_BITS-1:0]   m_ff;
   logic [JOB_BITS-1:0]    cur_job_ff, job_ff;
   logic [TOTAL_BITS-1:0]  sum_ff, best_tot_ff;
   logic [SPAN_BITS-1:0]   best_span_ff, result_ff;
   logic                   have_ff, final_ff;
   logic [MAX_JOBS-1:0]    picked_ff;
   logic                   rsp_valid_ff;
   logic [SPAN_BITS-1:0]   rsp_makespan_ff;

   logic [TIME_BITS-1:0]   tt_mem [1 << TT_ADDR_BITS];
   logic [TIME_BITS-1:0]   tt_rd_ff;
   logic [TOTAL_BITS-1:0]  jt_mem [MAX_JOBS];
   logic [TOTAL_BITS-1:0]  jt_rd_ff;
   logic [JOB_BITS-1:0]    bo_mem [MAX_JOBS];
   logic [JOB_BITS-1:0]    bo_rd_ff;

   logic                    accept, m_last, k_last, rsp_free;
   logic [COUNT_BITS-1:0]   len, cnt_dec;
   logic [TOTAL_BITS-1:0]   sum_next;
   logic [TT_ADDR_BITS-1:0] tt_raddr;
   logic                    jt_we;
   logic [JOB_BITS-1:0]     bo_raddr, bo_waddr, bo_wdata;
   logic                    bo_we;
   span_ctrl_type           span_ctrl;
   logic [SPAN_BITS-1:0]    span;

   assign nj = (job_count_ff > COUNT_BITS'(MAX_JOBS)) ? COUNT_BITS'(MAX_JOBS) : job_count_ff;
   assign nm = (machine_count_ff > MCOUNT_BITS'(MAX_MACHINES)) ?
               MCOUNT_BITS'(MAX_MACHINES) : machine_count_ff;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign m_last    = ({1'b0, m_ff} == (nm - MCOUNT_BITS'(1)));
   assign len       = final_ff ? placed_ff : (placed_ff + COUNT_BITS'(1));
   assign k_last    = (cnt_ff == (len - COUNT_BITS'(1)));
   assign cnt_dec   = cnt_ff - COUNT_BITS'(1);
   assign sum_next  = ((m_ff == '0) ? '0 : sum_ff) + TOTAL_BITS'(tt_rd_ff);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // register port
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_MACHINE_COUNT) ?
                       {{(32-MCOUNT_BITS){1'b0}}, machine_count_ff} :
                       {{(32-COUNT_BITS){1'b0}}, job_count_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         job_count_ff     <= COUNT_BITS'(1);
         machine_count_ff <= MCOUNT_BITS'(1);
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         unique case (csr_paddr[2])
            REG_JOB_COUNT:     job_count_ff     <= csr_pwdata[COUNT_BITS-1:0];
            REG_MACHINE_COUNT: machine_count_ff <= csr_pwdata[MCOUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // memories
   always_ff @(posedge clock) begin
      if (accept) begin
         tt_mem[{req_job_index, req_machine_index}] <= req_proc_time;
      end
      tt_rd_ff <= tt_mem[tt_raddr];
   end

   always_ff @(posedge clock) begin
      if (jt_we) begin
         jt_mem[cnt_ff[JOB_BITS-1:0]] <= sum_next;
      end
      jt_rd_ff <= jt_mem[cnt_ff[JOB_BITS-1:0]];
   end

   always_ff @(posedge clock) begin
      if (bo_we) begin
         bo_mem[bo_waddr] <= bo_wdata;
      end
      bo_rd_ff <= bo_mem[bo_raddr];
   end

   neh_span u_span (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (span_ctrl),
      .proc_time (tt_rd_ff),
      .span      (span)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_last_entry) begin
               state_in = ((nj == '0) || (nm == '0)) ? ST_DONE : ST_TOT_ADDR;
            end
         end
         ST_TOT_ADDR: state_in = ST_TOT_ACC;
         ST_TOT_ACC: begin
            if (m_last && (cnt_ff == (nj - COUNT_BITS'(1)))) begin
               state_in = ST_SEL_ADDR;
            end else begin
               state_in = ST_TOT_ADDR;
            end
         end
         ST_SEL_ADDR: state_in = ST_SEL_CMP;
         ST_SEL_CMP: begin
            state_in = (cnt_ff == (nj - COUNT_BITS'(1))) ? ST_INS_INIT : ST_SEL_ADDR;
         end
         ST_INS_INIT:    state_in = ST_TRIAL_START;
         ST_TRIAL_START: state_in = ST_ELEM_ADDR;
         ST_ELEM_ADDR:   state_in = ST_ELEM_WAIT;
         ST_ELEM_WAIT:   state_in = ST_MAC_ADDR;
         ST_MAC_ADDR:    state_in = ST_MAC_STEP;
         ST_MAC_STEP: begin
            if (m_last) begin
               state_in = k_last ? ST_TRIAL_END : ST_ELEM_ADDR;
            end else begin
               state_in = ST_MAC_ADDR;
            end
         end
         ST_TRIAL_END: begin
            if (final_ff) begin
               state_in = ST_DONE;
            end else if (pos_ff == placed_ff) begin
               state_in = ST_SHIFT;
            end else begin
               state_in = ST_TRIAL_START;
            end
         end
         ST_SHIFT: begin
            if (cnt_ff > best_slot_ff) begin
               state_in = ST_SHIFT_WR;
            end else if ((placed_ff + COUNT_BITS'(1)) == nj) begin
               state_in = ST_TRIAL_START;
            end else begin
               state_in = ST_SEL_ADDR;
            end
         end
         ST_SHIFT_WR: state_in = ST_SHIFT;
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      tt_raddr  = {cur_job_ff, m_ff};
      jt_we     = 1'b0;
      bo_raddr  = cnt_ff[JOB_BITS-1:0];
      bo_we     = 1'b0;
      bo_waddr  = cnt_ff[JOB_BITS-1:0];
      bo_wdata  = bo_rd_ff;
      span_ctrl = '{clear: 1'b0, step: 1'b0, first: (m_ff == '0), machine: m_ff};
      unique case (state_ff)
         ST_TOT_ADDR: tt_raddr = {cnt_ff[JOB_BITS-1:0], m_ff};
         ST_TOT_ACC:  jt_we = m_last;
         ST_TRIAL_START: span_ctrl.clear = 1'b1;
         ST_ELEM_ADDR: begin
            if (!final_ff && (cnt_ff >= pos_ff)) begin
               bo_raddr = cnt_dec[JOB_BITS-1:0];
            end
         end
         ST_MAC_STEP: span_ctrl.step = 1'b1;
         ST_SHIFT: begin
            bo_raddr = cnt_dec[JOB_BITS-1:0];
            if (!(cnt_ff > best_slot_ff)) begin
               bo_we    = 1'b1;
               bo_waddr = best_slot_ff[JOB_BITS-1:0];
               bo_wdata = job_ff;
            end
         end
         ST_SHIFT_WR: bo_we = 1'b1;
         default: ;
      endcase
   end

   // sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         final_ff     <= 1'b0;
         have_ff      <= 1'b0;
         placed_ff    <= '0;
         best_slot_ff <= '0;
         best_span_ff <= '1;
         picked_ff    <= '0;
         cnt_ff       <= '0;
         pos_ff       <= '0;
         m_ff         <= '0;
      end else begin
         state_ff <= state_in;
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept && req_last_entry) begin
                  cnt_ff    <= '0;
                  m_ff      <= '0;
                  picked_ff <= '0;
                  placed_ff <= '0;
                  final_ff  <= 1'b0;
                  have_ff   <= 1'b0;
                  result_ff <= '0;
               end
            end
            ST_TOT_ACC: begin
               sum_ff <= sum_next;
               if (m_last) begin
                  m_ff    <= '0;
                  have_ff <= 1'b0;
                  cnt_ff  <= (cnt_ff == (nj - COUNT_BITS'(1))) ? '0 : cnt_ff + COUNT_BITS'(1);
               end else begin
                  m_ff <= m_ff + MACH_BITS'(1);
               end
            end
            ST_SEL_CMP: begin
               if (!picked_ff[cnt_ff[JOB_BITS-1:0]] && (!have_ff || (jt_rd_ff > best_tot_ff))) begin
                  have_ff     <= 1'b1;
                  best_tot_ff <= jt_rd_ff;
                  job_ff      <= cnt_ff[JOB_BITS-1:0];
               end
               cnt_ff <= (cnt_ff == (nj - COUNT_BITS'(1))) ? '0 : cnt_ff + COUNT_BITS'(1);
            end
            ST_INS_INIT: begin
               picked_ff[job_ff] <= 1'b1;
               pos_ff            <= '0;
            end
            ST_TRIAL_START: cnt_ff <= '0;
            ST_ELEM_WAIT: begin
               cur_job_ff <= (!final_ff && (cnt_ff == pos_ff)) ? job_ff : bo_rd_ff;
               m_ff       <= '0;
            end
            ST_MAC_STEP: begin
               if (m_last) begin
                  m_ff   <= '0;
                  cnt_ff <= cnt_ff + COUNT_BITS'(1);
               end else begin
                  m_ff <= m_ff + MACH_BITS'(1);
               end
            end
            ST_TRIAL_END: begin
               if (final_ff) begin
                  result_ff <= span;
               end else begin
                  if ((pos_ff == '0) || (span < best_span_ff)) begin
                     best_span_ff <= span;
                     best_slot_ff <= pos_ff;
                  end
                  if (pos_ff == placed_ff) begin
                     cnt_ff <= placed_ff;
                  end else begin
                     pos_ff <= pos_ff + COUNT_BITS'(1);
                  end
               end
            end
            ST_SHIFT: begin
               if (!(cnt_ff > best_slot_ff)) begin
                  placed_ff <= placed_ff + COUNT_BITS'(1);
                  if ((placed_ff + COUNT_BITS'(1)) == nj) begin
                     final_ff <= 1'b1;
                  end else begin
                     cnt_ff  <= '0;
                     have_ff <= 1'b0;
                  end
               end
            end
            ST_SHIFT_WR: cnt_ff <= cnt_dec;
            ST_DONE: begin
               if (rsp_free) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_makespan_ff <= result_ff;
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_makespan = rsp_makespan_ff;

endmodule

[sim/neh_span_checker.sv]
// Checker for the NEH flow-shop scheduler: watches the request, result and
// register ports, predicts each makespan and compares. Depends on neh_pkg.
`timescale 1ns / 1ps
module neh_span_checker import neh_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic [JOB_BITS-1:0]  req_job_index,
   input  logic [MACH_BITS-1:0] req_machine_index,
   input  logic [TIME_BITS-1:0] req_proc_time,
   input  logic                 req_last_entry,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic [SPAN_BITS-1:0] rsp_makespan,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic                 csr_pready,
   input  logic [2:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output int                   mismatches,
   output int                   pending,
   output int                   spans_checked
);

   logic [TIME_BITS-1:0]   proc_table [MAX_JOBS*MAX_MACHINES];
   logic [COUNT_BITS-1:0]  jobs_reg;
   logic [MCOUNT_BITS-1:0] machines_reg;
   logic [SPAN_BITS-1:0]   expected_spans [$];

   function automatic longint unsigned seq_span(int seq[MAX_JOBS], int len, int nm);
      longint unsigned done_at [MAX_MACHINES];
      longint unsigned ready;
      for (int m = 0; m < MAX_MACHINES; m++) done_at[m] = 0;
      for (int i = 0; i < len; i++) begin
         for (int m = 0; m < nm; m++) begin
            ready = done_at[m];
            if (m > 0 && done_at[m-1] > ready) ready = done_at[m-1];
            done_at[m] = ready + proc_table[seq[i]*MAX_MACHINES + m];
         end
      end
      return nm > 0 ? done_at[nm-1] : 0;
   endfunction

   function automatic logic [SPAN_BITS-1:0] neh_makespan();
      int nj, nm, k, placed, slot, t;
      longint unsigned total [MAX_JOBS];
      longint unsigned best, sp;
      int rank [MAX_JOBS];
      int order [MAX_JOBS];
      int trial [MAX_JOBS];
      nj = jobs_reg > MAX_JOBS ? MAX_JOBS : jobs_reg;
      nm = machines_reg > MAX_MACHINES ? MAX_MACHINES : machines_reg;
      if (nj == 0 || nm == 0) return '0;
      for (int i = 0; i < MAX_JOBS; i++) begin
         rank[i] = 0; order[i] = 0; trial[i] = 0; total[i] = 0;
      end
      for (int i = 0; i < nj; i++)
         for (int m = 0; m < nm; m++) total[i] += proc_table[i*MAX_MACHINES + m];
      for (int i = 0; i < nj; i++) begin
         k = i;
         while (k > 0 && total[rank[k-1]] < total[i]) begin
            rank[k] = rank[k-1];
            k--;
         end
         rank[k] = i;
      end
      placed = 0;
      for (int i = 0; i < nj; i++) begin
         best = 0;
         slot = 0;
         for (int pos = 0; pos <= placed; pos++) begin
            t = 0;
            for (int q = 0; q <= placed; q++) begin
               if (q == pos) trial[q] = rank[i];
               else begin
                  trial[q] = order[t];
                  t++;
               end
            end
            sp = seq_span(trial, placed + 1, nm);
            if (pos == 0 || sp < best) begin
               best = sp;
               slot = pos;
            end
         end
         for (int q = placed; q > slot; q--) order[q] = order[q-1];
         order[slot] = rank[i];
         placed++;
      end
      return SPAN_BITS'(seq_span(order, placed, nm));
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         jobs_reg <= 1;
         machines_reg <= 1;
         expected_spans.delete();
         mismatches <= 0;
         spans_checked <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr[1:0] == 2'b00) begin
            if (csr_paddr[2] == REG_JOB_COUNT) jobs_reg <= csr_pwdata[COUNT_BITS-1:0];
            else machines_reg <= csr_pwdata[MCOUNT_BITS-1:0];
         end
         if (req_valid && !req_stall) begin
            proc_table[{req_job_index, req_machine_index}] = req_proc_time;
            if (req_last_entry)
               expected_spans.insert(expected_spans.size(), neh_makespan());
         end
         if (rsp_valid && !rsp_stall) begin
            spans_checked <= spans_checked + 1;
            if (expected_spans.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected makespan %0d with nothing pending", rsp_makespan);
               mismatches <= mismatches + 1;
            end else begin
               if (rsp_makespan !== expected_spans[0]) begin
                  if (mismatches < 10)
                     $display("makespan mismatch: expected %0d, got %0d",
                              expected_spans[0], rsp_makespan);
                  mismatches <= mismatches + 1;
               end
               void'(expected_spans.pop_front());
            end
         end
      end
   end

   assign pending = expected_spans.size();

endmodule

[sim/tb.sv]
// Testbench top for neh_flow_shop_scheduler_unit: clock, reset, request and
// register stimulus, verdict. Depends on neh_pkg and neh_span_checker.
`timescale 1ns / 1ps
module tb;
   import neh_pkg::*;

   logic                 clock = 0;
   logic                 reset = 1;
   logic                 req_valid = 0;
   logic                 req_stall;
   logic [JOB_BITS-1:0]  req_job_index = 0;
   logic [MACH_BITS-1:0] req_machine_index = 0;
   logic [TIME_BITS-1:0] req_proc_time = 0;
   logic                 req_last_entry = 0;
   logic                 rsp_valid;
   logic                 rsp_stall = 0;
   logic [SPAN_BITS-1:0] rsp_makespan;
   logic                 csr_psel = 0;
   logic                 csr_penable = 0;
   logic                 csr_pwrite = 0;
   logic [2:0]           csr_paddr = 0;
   logic [31:0]          csr_pwdata = 0;
   logic [31:0]          csr_prdata;
   logic                 csr_pready;
   int                   mismatches, pending, spans_checked;
   int                   send_idle_pct = 0, recv_stall_pct = 0;
   int                   hold_cycles = 0;
   int                   quiet_cycles = 0;
   int                   requests_sent = 0;

   always #10 clock = ~clock;

   neh_flow_shop_scheduler_unit DUT (.*);

   neh_span_checker checker_i (.*);

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall = 1;
         hold_cycles--;
      end else
         rsp_stall = ($urandom_range(99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_psel && csr_penable))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 4000000) begin
         $display("neh_flow_shop_scheduler_unit verification failed");
         $finish;
      end
   end

   task automatic csr_write(logic reg_sel, int value);
      @(negedge clock);
      csr_psel = 1; csr_penable = 0; csr_pwrite = 1;
      csr_paddr = {reg_sel, 2'b00}; csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1;
      @(negedge clock);
      csr_psel = 0; csr_penable = 0; csr_pwrite = 0;
   endtask

   task automatic send(int job, int mach, int ptime, bit last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 0;
         @(negedge clock);
      end
      req_valid = 1;
      req_job_index = job; req_machine_index = mach;
      req_proc_time = ptime; req_last_entry = last;
      do @(posedge clock); while (req_stall);
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic settle();
      req_valid = 0;
      do @(posedge clock); while (pending != 0);
      repeat (8) @(negedge clock);
   endtask

   task automatic configure(int jobs, int machs);
      settle();
      csr_write(REG_JOB_COUNT, jobs);
      csr_write(REG_MACHINE_COUNT, machs);
   endtask

   function automatic int rand_time();
      case ($urandom_range(9))
         0: return 0;
         1: return 16'hFFFF;
         2: return $urandom_range(15);
         default: return $urandom_range(16'hFFFF);
      endcase
   endfunction

   task automatic instance_run(int max_items);
      int n, nj;
      n = $urandom_range(1, max_items);
      nj = $urandom_range(1, 10);
      for (int i = 0; i < n; i++)
         send($urandom_range(99) < 80 ? $urandom_range(nj - 1) : $urandom_range(63),
              $urandom_range(15), rand_time(), i == n - 1);
   endtask

   task automatic random_config();
      int jobs, machs;
      jobs = $urandom_range(99) < 8 ? 0 : $urandom_range(1, 8);
      machs = $urandom_range(99) < 8 ? $urandom_range(17, 31) : $urandom_range(1, 16);
      configure(jobs, machs);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // fill every entry a later schedule can read: first 8 jobs on all
      // machines, all jobs on the first two machines
      for (int j = 0; j < MAX_JOBS; j++)
         for (int m = 0; m < MAX_MACHINES; m++)
            if (j < 8 || m < 2)
               send(j, m, rand_time(), j == MAX_JOBS - 1 && m == 1);

      // directed: extremes, equal totals, zero counts, saturation
      configure(3, 16);
      for (int m = 0; m < 16; m++) send(0, m, 16'hFFFF, 0);
      send(1, 15, 0, 0);
      send(63, 15, 16'hFFFF, 0);
      send(2, 0, 16'h1234, 1);
      configure(3, 2);
      for (int j = 0; j < 3; j++) begin
         send(j, 0, 5, 0);
         send(j, 1, 7, j == 2);
      end
      configure(0, 5);
      send(5, 5, 9, 1);
      configure(4, 0);
      send(1, 1, 1, 1);
      configure(127, 1);
      send(10, 0, 3, 1);
      configure(64, 2);
      send(20, 1, 16'hFFFF, 1);
      configure(3, 31);
      send(2, 15, 16'hFFFF, 1);

      // random: three idling profiles
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = phase == 0 ? 21 : phase == 1 ? 70 : 0;
         recv_stall_pct = phase == 0 ? 70 : phase == 1 ? 21 : 0;
         for (int k = 0; k < 22; k++) begin
            random_config();
            if (k == 5) begin
               hold_cycles = 30000;
               instance_run(6);
               instance_run(6);
               instance_run(6);
            end else
               instance_run(16);
         end
      end

      settle();
      repeat (50) @(negedge clock);
      $display("run covered %0d requests and %0d makespans over full-table, directed and",
               requests_sent, spans_checked);
      $display("random instances with zero, saturated and extreme job and machine counts");
      if (mismatches == 0 && pending == 0)
         $display("neh_flow_shop_scheduler_unit verification clean");
      else
         $display("neh_flow_shop_scheduler_unit verification failed");
      $finish;
   end

endmodule
